@@ design/csem_pkg.sv @@
// ----------------------------------------------------------------------------
// csem_pkg
// Shared constants, codes and types of the counting semaphore with its
// wait queue, kept in FIFO or priority order.
// ----------------------------------------------------------------------------
package csem_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int THREAD_BITS = 5;
    localparam int PRIO_BITS   = 8;
    localparam int COUNT_W     = 16;

    localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = THREAD_BITS + PRIO_BITS;

    // input tdata: thread_id, priority_req, will_wait, scheduler_disabled, timed_out
    localparam int WW_BIT      = THREAD_BITS + PRIO_BITS;
    localparam int SD_BIT      = WW_BIT + 1;
    localparam int TO_BIT      = WW_BIT + 2;
    localparam int S_FIELDS_W  = THREAD_BITS + PRIO_BITS + 3;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_TUSER_W   = 2;

    // output tdata: woken_thread, count_now
    localparam int M_FIELDS_W  = THREAD_BITS + COUNT_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_TUSER_W   = 3;

    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [1:0] ACT_TAKE    = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_RESUME  = 2'd2;

    localparam logic REG_ORDER = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_TIMEOUT   = 3'd1,
        STAT_SCHED_OFF = 3'd2,
        STAT_QUEUED    = 3'd3,
        STAT_AGAIN     = 3'd4,
        STAT_WOKE      = 3'd5,
        STAT_NO_WAITER = 3'd6,
        STAT_FULL      = 3'd7
    } status_t;

    typedef enum logic [4:0] {
        FSM_IDLE  = 5'b00001,
        FSM_SCAN  = 5'b00010,
        FSM_PASS  = 5'b00100,
        FSM_PLACE = 5'b01000,
        FSM_RESP  = 5'b10000
    } state_t;

endpackage

@@ design/csem_ram.sv @@
// ----------------------------------------------------------------------------
// csem_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module csem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/counting_semaphore_priority_waitq_top.sv @@
// ----------------------------------------------------------------------------
// counting_semaphore_priority_waitq_top
// Counting semaphore with a bounded wait queue kept in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ stream (action in s_tuser), one result per
//   request leaves on the m_ stream (status in m_tuser). The APB port sets
//   the ordering mode and loads the count; write it only while idle.
//   Take, release and resume work on the count; a blocking take queues the
//   caller, a release pops the head waiter.
// Request flow:
//   One request at a time; the next request is accepted in the cycle
//   after the result register loads. Count-only requests go from IDLE
//   through RESP to the result register.
//   A queueing take scans the queue (SCAN), moves the entries between the
//   removal and insertion points (PASS) and writes the new entry (PLACE);
//   a take that finds the queue full skips the move and the write.
//   A release with waiters reads the whole queue, passes its head to
//   woken_thread and shifts the rest; the single RAM port pair moves
//   one entry per cycle.
// Reset and stall:
//   Reset empties the queue and clears the count, mode and valid flags.
//   A stalled result is held in the output register; the next request is
//   taken once that result has been loaded.
// ----------------------------------------------------------------------------
module counting_semaphore_priority_waitq_top
    import csem_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata: thread_id, priority_req, will_wait, scheduler_disabled, timed_out
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser: action
    input  logic [S_TUSER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata: woken_thread, count_now
    output logic [M_TDATA_W-1:0]  m_tdata,
    // m_tuser: status
    output logic [M_TUSER_W-1:0]  m_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready
);

    state_t state_reg, state_next;

    logic                   order_reg, order_next;
    logic [COUNT_W-1:0]     init_count_reg, init_count_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]       total_reg, total_next;

    logic [THREAD_BITS-1:0] tid_reg, tid_next;
    logic [PRIO_BITS-1:0]   prio_reg, prio_next;
    logic                   rel_reg, rel_next;

    logic [CNT_W-1:0]       iss_idx_reg, iss_idx_next;
    logic                   sc_vld_reg, sc_vld_next;
    logic [IDX_W-1:0]       sc_idx_reg, sc_idx_next;
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       r_reg, r_next;
    logic                   brk_reg, brk_next;
    logic [CNT_W-1:0]       p_reg, p_next;

    logic                   iss_on_reg, iss_on_next;
    logic                   up_reg, up_next;
    logic                   first_reg, first_next;
    logic [IDX_W-1:0]       src_reg, src_next;
    logic [IDX_W-1:0]       end_reg, end_next;
    logic                   mv_vld_reg, mv_vld_next;
    logic                   mv_skip_reg, mv_skip_next;
    logic [IDX_W-1:0]       mv_src_reg, mv_src_next;
    logic [IDX_W-1:0]       place_reg, place_next;

    status_t                res_status_reg, res_status_next;
    logic [THREAD_BITS-1:0] res_woken_reg, res_woken_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    status_t                m_status_reg, m_status_next;
    logic [THREAD_BITS-1:0] m_woken_reg, m_woken_next;
    logic [COUNT_W-1:0]     m_count_reg, m_count_next;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic                   ram_re;
    logic [IDX_W-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]     ram_rdata;

    logic                   s_accept;
    logic                   apb_wr;
    logic [THREAD_BITS-1:0] in_tid;
    logic [PRIO_BITS-1:0]   in_prio;
    logic [THREAD_BITS-1:0] rd_id;
    logic [PRIO_BITS-1:0]   rd_prio;

    assign s_tready = (state_reg == FSM_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign apb_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign in_tid   = s_tdata[THREAD_BITS-1:0];
    assign in_prio  = s_tdata[THREAD_BITS +: PRIO_BITS];
    assign rd_id    = ram_rdata[ENTRY_W-1 -: THREAD_BITS];
    assign rd_prio  = ram_rdata[PRIO_BITS-1:0];

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = M_TUSER_W'(m_status_reg);
    assign m_tdata  = M_TDATA_W'({m_count_reg, m_woken_reg});

    always_comb begin
        prdata = '0;
        unique case (paddr[PADDR_W-1:2])
            REG_ORDER: prdata = PDATA_W'(order_reg);
            REG_COUNT: prdata = PDATA_W'(init_count_reg);
            default:   prdata = '0;
        endcase
    end

    csem_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_waitq_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        logic [CNT_W-1:0] j;
        logic [CNT_W-1:0] found_cnt;
        logic [CNT_W-1:0] fin_r;
        logic [CNT_W-1:0] fin_p;

        state_next      = state_reg;
        order_next      = order_reg;
        init_count_next = init_count_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        tid_next        = tid_reg;
        prio_next       = prio_reg;
        rel_next        = rel_reg;
        iss_idx_next    = iss_idx_reg;
        sc_vld_next     = sc_vld_reg;
        sc_idx_next     = sc_idx_reg;
        found_next      = found_reg;
        r_next          = r_reg;
        brk_next        = brk_reg;
        p_next          = p_reg;
        iss_on_next     = iss_on_reg;
        up_next         = up_reg;
        first_next      = first_reg;
        src_next        = src_reg;
        end_next        = end_reg;
        mv_vld_next     = mv_vld_reg;
        mv_skip_next    = mv_skip_reg;
        mv_src_next     = mv_src_reg;
        place_next      = place_reg;
        res_status_next = res_status_reg;
        res_woken_next  = res_woken_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_status_next   = m_status_reg;
        m_woken_next    = m_woken_reg;
        m_count_next    = m_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = '0;
        j               = '0;
        found_cnt       = CNT_W'(found_reg);
        fin_r           = found_reg ? CNT_W'(r_reg) : total_reg;
        fin_p           = brk_reg ? p_reg : (total_reg - found_cnt);

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            FSM_IDLE: begin
                if (s_accept) begin
                    tid_next       = in_tid;
                    prio_next      = in_prio;
                    res_woken_next = '0;
                    rel_next       = 1'b0;
                    state_next     = FSM_RESP;
                    case (s_tuser)
                        ACT_TAKE: begin
                            if (count_reg != '0) begin
                                count_next      = count_reg - 1'b1;
                                res_status_next = STAT_OK;
                            end else if (s_tdata[SD_BIT]) begin
                                res_status_next = STAT_SCHED_OFF;
                            end else if (!s_tdata[WW_BIT]) begin
                                res_status_next = STAT_TIMEOUT;
                            end else begin
                                found_next   = 1'b0;
                                brk_next     = 1'b0;
                                iss_idx_next = '0;
                                sc_vld_next  = 1'b0;
                                state_next   = FSM_SCAN;
                            end
                        end
                        ACT_RELEASE: begin
                            if (count_reg != '1) begin
                                count_next = count_reg + 1'b1;
                            end
                            if (total_reg != '0) begin
                                res_status_next = STAT_WOKE;
                                rel_next        = 1'b1;
                                up_next         = 1'b0;
                                first_next      = 1'b1;
                                src_next        = '0;
                                end_next        = IDX_W'(total_reg - 1'b1);
                                iss_on_next     = 1'b1;
                                mv_vld_next     = 1'b0;
                                total_next      = total_reg - 1'b1;
                                state_next      = FSM_PASS;
                            end else begin
                                res_status_next = STAT_NO_WAITER;
                            end
                        end
                        ACT_RESUME: begin
                            if (s_tdata[TO_BIT]) begin
                                res_status_next = STAT_TIMEOUT;
                            end else if (count_reg != '0) begin
                                count_next      = count_reg - 1'b1;
                                res_status_next = STAT_OK;
                            end else begin
                                res_status_next = STAT_AGAIN;
                            end
                        end
                        default: begin
                            res_status_next = STAT_AGAIN;
                        end
                    endcase
                end
            end

            FSM_SCAN: begin
                if (iss_idx_reg < total_reg) begin
                    ram_re       = 1'b1;
                    ram_raddr    = IDX_W'(iss_idx_reg);
                    sc_vld_next  = 1'b1;
                    sc_idx_next  = IDX_W'(iss_idx_reg);
                    iss_idx_next = iss_idx_reg + 1'b1;
                end else begin
                    sc_vld_next = 1'b0;
                end

                if (sc_vld_reg) begin
                    j = found_reg ? (CNT_W'(sc_idx_reg) - 1'b1) : CNT_W'(sc_idx_reg);
                    if (!found_reg && (rd_id == tid_reg)) begin
                        found_next = 1'b1;
                        r_next     = sc_idx_reg;
                    end else if (!brk_reg && order_reg) begin
                        if (rd_prio > prio_reg) begin
                            brk_next = 1'b1;
                            p_next   = j;
                        end else if (rd_prio == prio_reg) begin
                            brk_next = 1'b1;
                            p_next   = j + 1'b1;
                        end
                    end
                end

                if ((iss_idx_reg == total_reg) && !sc_vld_reg) begin
                    if (!found_reg && (total_reg == CNT_W'(QUEUE_DEPTH))) begin
                        res_status_next = STAT_FULL;
                        state_next      = FSM_RESP;
                    end else begin
                        res_status_next = STAT_QUEUED;
                        total_next      = total_reg - found_cnt + 1'b1;
                        place_next      = IDX_W'(fin_p);
                        mv_vld_next     = 1'b0;
                        end_next        = IDX_W'(fin_p);
                        if (fin_p < fin_r) begin
                            up_next     = 1'b1;
                            first_next  = 1'b0;
                            src_next    = IDX_W'(fin_r - 1'b1);
                            iss_on_next = 1'b1;
                            state_next  = FSM_PASS;
                        end else if (fin_p == fin_r) begin
                            state_next = FSM_PLACE;
                        end else begin
                            up_next     = 1'b0;
                            first_next  = 1'b1;
                            src_next    = IDX_W'(fin_r);
                            iss_on_next = 1'b1;
                            state_next  = FSM_PASS;
                        end
                    end
                end
            end

            FSM_PASS: begin
                if (iss_on_reg) begin
                    ram_re       = 1'b1;
                    ram_raddr    = src_reg;
                    mv_vld_next  = 1'b1;
                    mv_src_next  = src_reg;
                    mv_skip_next = first_reg;
                    first_next   = 1'b0;
                    if (src_reg == end_reg) begin
                        iss_on_next = 1'b0;
                    end else begin
                        src_next = up_reg ? (src_reg - 1'b1) : (src_reg + 1'b1);
                    end
                end else begin
                    mv_vld_next = 1'b0;
                end

                if (mv_vld_reg) begin
                    if (mv_skip_reg) begin
                        if (rel_reg) begin
                            res_woken_next = rd_id;
                        end
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = up_reg ? (mv_src_reg + 1'b1) : (mv_src_reg - 1'b1);
                        ram_wdata = ram_rdata;
                    end
                end

                if (!iss_on_reg && !mv_vld_reg) begin
                    state_next = rel_reg ? FSM_RESP : FSM_PLACE;
                end
            end

            FSM_PLACE: begin
                ram_we     = 1'b1;
                ram_waddr  = place_reg;
                ram_wdata  = {tid_reg, prio_reg};
                state_next = FSM_RESP;
            end

            FSM_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_woken_next  = res_woken_reg;
                    m_count_next  = count_reg;
                    state_next    = FSM_IDLE;
                end
            end

            default: begin
                state_next = FSM_IDLE;
            end
        endcase

        if (apb_wr) begin
            unique case (paddr[PADDR_W-1:2])
                REG_ORDER: order_next = pwdata[0];
                REG_COUNT: begin
                    init_count_next = pwdata[COUNT_W-1:0];
                    count_next      = pwdata[COUNT_W-1:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= FSM_IDLE;
            order_reg      <= 1'b0;
            init_count_reg <= '0;
            count_reg      <= '0;
            total_reg      <= '0;
            sc_vld_reg     <= 1'b0;
            iss_on_reg     <= 1'b0;
            mv_vld_reg     <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            order_reg      <= order_next;
            init_count_reg <= init_count_next;
            count_reg      <= count_next;
            total_reg      <= total_next;
            sc_vld_reg     <= sc_vld_next;
            iss_on_reg     <= iss_on_next;
            mv_vld_reg     <= mv_vld_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tid_reg        <= tid_next;
        prio_reg       <= prio_next;
        rel_reg        <= rel_next;
        iss_idx_reg    <= iss_idx_next;
        sc_idx_reg     <= sc_idx_next;
        found_reg      <= found_next;
        r_reg          <= r_next;
        brk_reg        <= brk_next;
        p_reg          <= p_next;
        up_reg         <= up_next;
        first_reg      <= first_next;
        src_reg        <= src_next;
        end_reg        <= end_next;
        mv_skip_reg    <= mv_skip_next;
        mv_src_reg     <= mv_src_next;
        place_reg      <= place_next;
        res_status_reg <= res_status_next;
        res_woken_reg  <= res_woken_next;
        m_status_reg   <= m_status_next;
        m_woken_reg    <= m_woken_next;
        m_count_reg    <= m_count_next;
    end

    a_ram_write_in_queue_work: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == FSM_PASS) || (state_reg == FSM_PLACE))
        else $error("queue RAM written outside a queue update");

    a_result_from_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == FSM_RESP))
        else $error("result raised without a pending response");

    a_count_changes_on_request: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(count_reg) && $past(aresetn) |-> $past(s_accept || apb_wr))
        else $error("count changed without a transaction or register write");

    a_total_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FSM_RESP) |-> (total_reg <= CNT_W'(QUEUE_DEPTH)))
        else $error("waiter total exceeds queue depth");

    a_woken_only_on_wake: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && (m_status_reg != STAT_WOKE) |-> (m_woken_reg == '0))
        else $error("woken thread reported without a wake");

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the counting semaphore with its bounded wait queue.
// A directed table covers the count and queue corner cases, including a full
// queue, a retake by a thread that is already waiting and a count held at its
// maximum. Random phases follow, each loading an ordering mode and start
// count from a per-phase table. Every request is run through a local model
// of the count and wait queue, and each result on the m_ stream is compared
// field by field with the oldest prediction. Both streams stall at random,
// with one long back-pressure stretch and one drain pause.
// ----------------------------------------------------------------------------
module tb;
    import csem_pkg::*;

    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 220;
    localparam int SETTLE      = 2 * QUEUE_DEPTH + 8;
    localparam int LONG_HOLD   = 80;
    localparam int QUIET_LIMIT = 4000;
    localparam int PLAN_ROWS   = 22;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        status_t                st;
        logic [THREAD_BITS-1:0] woken;
        logic [COUNT_W-1:0]     cnt;
    } result_t;

    typedef struct packed {
        logic [THREAD_BITS-1:0] id;
        logic [PRIO_BITS-1:0]   prio;
    } waiter_t;

    // cnt carries the register value on a ROW_CFG row
    typedef struct packed {
        row_kind_t              kind;
        logic                   reg_sel;
        logic [1:0]             act;
        logic [THREAD_BITS-1:0] tid;
        logic [PRIO_BITS-1:0]   prio;
        logic                   ww;
        logic                   sd;
        logic                   tmo;
        logic [4:0]             reps;
        logic                   chk;
        status_t                st;
        logic [THREAD_BITS-1:0] woken;
        logic [COUNT_W-1:0]     cnt;
    } plan_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // local copy of the semaphore
    logic [COUNT_W-1:0] sem_level = '0;
    logic               prio_mode = 1'b0;
    waiter_t            waitq[$];
    result_t            pending_results[$];
    result_t            popped;

    int  errors        = 0;
    int  requests_sent = 0;
    int  results_seen  = 0;
    int  retakes       = 0;
    int  deepest       = 0;
    int  quiet_cycles  = 0;
    int  status_hits [8];
    bit  idle_on       = 1'b1;
    bit  long_hold     = 1'b0;

    logic phase_order [PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    int   phase_count [PHASES] = '{0, 65535, 0, 3, 0};
    int   phase_take  [PHASES] = '{55, 50, 65, 45, 55};

    plan_row_t plan [PLAN_ROWS] = '{
        '{ROW_ITEM, REG_ORDER, ACT_RELEASE, 31, 255, 1, 1, 1, 1, 1, STAT_NO_WAITER, 0, 1},
        '{ROW_ITEM, REG_ORDER, ACT_TAKE,     0,   0, 0, 0, 0, 1, 1, STAT_OK,        0, 0},
        '{ROW_ITEM, REG_ORDER, ACT_TAKE,     1,   0, 1, 1, 0, 1, 1, STAT_SCHED_OFF, 0, 0},
        '{ROW_ITEM, REG_ORDER, ACT_TAKE,     1,   0, 0, 0, 0, 1, 1, STAT_TIMEOUT,   0, 0},
        '{ROW_ITEM, REG_ORDER, ACT_RESUME,  31, 255, 1, 1, 1, 1, 1, STAT_TIMEOUT,   0, 0},
        '{ROW_ITEM, REG_ORDER, ACT_RESUME,   0,   0, 0, 0, 0, 1, 1, STAT_AGAIN,     0, 0},
        '{ROW_ITEM, REG_ORDER, ACT_SPARE,   31, 255, 1, 1, 1, 1, 1, STAT_AGAIN,     0, 0},
        '{ROW_ITEM, REG_ORDER, ACT_TAKE,    31, 255, 1, 0, 0, 1, 1, STAT_QUEUED,    0, 0},
        '{ROW_ITEM, REG_ORDER, ACT_TAKE,     0, 200, 1, 0, 0, 15, 0, STAT_OK,       0, 0},
        '{ROW_ITEM, REG_ORDER, ACT_TAKE,    31,   0, 1, 0, 0, 1, 1, STAT_QUEUED,    0, 0},
        '{ROW_ITEM, REG_ORDER, ACT_TAKE,    20,   9, 1, 0, 0, 1, 1, STAT_FULL,      0, 0},
        '{ROW_ITEM, REG_ORDER, ACT_RELEASE,  0,   0, 0, 0, 0, 1, 0, STAT_OK,        0, 0},
        '{ROW_CFG,  REG_ORDER, ACT_TAKE,     0,   0, 0, 0, 0, 1, 0, STAT_OK,        0, 1},
        '{ROW_CFG,  REG_COUNT, ACT_TAKE,     0,   0, 0, 0, 0, 1, 0, STAT_OK,    0, 65535},
        '{ROW_ITEM, REG_ORDER, ACT_RELEASE,  0,   0, 0, 0, 0, 1, 0, STAT_OK,        0, 0},
        '{ROW_ITEM, REG_ORDER, ACT_TAKE,     5,  40, 1, 0, 0, 1, 0, STAT_OK,        0, 0},
        '{ROW_CFG,  REG_COUNT, ACT_TAKE,     0,   0, 0, 0, 0, 1, 0, STAT_OK,        0, 0},
        '{ROW_ITEM, REG_ORDER, ACT_TAKE,    25, 190, 1, 0, 0, 1, 0, STAT_OK,        0, 0},
        '{ROW_ITEM, REG_ORDER, ACT_TAKE,    26, 190, 1, 0, 0, 1, 0, STAT_OK,        0, 0},
        '{ROW_ITEM, REG_ORDER, ACT_TAKE,    31, 186, 1, 0, 0, 1, 0, STAT_OK,        0, 0},
        '{ROW_ITEM, REG_ORDER, ACT_RELEASE,  0,   0, 0, 0, 0, 1, 0, STAT_OK,        0, 0},
        '{ROW_ITEM, REG_ORDER, ACT_RESUME,   0,   0, 0, 0, 0, 1, 0, STAT_OK,        0, 0}
    };

    counting_semaphore_priority_waitq_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic result_t semaphore_step(
        logic [1:0]             act,
        logic [THREAD_BITS-1:0] tid,
        logic [PRIO_BITS-1:0]   prio,
        logic                   ww,
        logic                   sd,
        logic                   tmo
    );
        result_t r;
        waiter_t w;
        int      pos;
        r.st    = STAT_AGAIN;
        r.woken = '0;
        case (act)
            ACT_TAKE: begin
                if (sem_level != 0) begin
                    sem_level--;
                    r.st = STAT_OK;
                end else if (sd) begin
                    r.st = STAT_SCHED_OFF;
                end else if (!ww) begin
                    r.st = STAT_TIMEOUT;
                end else begin
                    // drop an earlier entry of the same thread
                    for (int i = 0; i < waitq.size(); i++) begin
                        if (waitq[i].id == tid) begin
                            waitq.delete(i);
                            retakes++;
                            break;
                        end
                    end
                    if (waitq.size() >= QUEUE_DEPTH) begin
                        r.st = STAT_FULL;
                    end else begin
                        pos = waitq.size();
                        if (prio_mode) begin
                            for (int i = 0; i < waitq.size(); i++) begin
                                if (waitq[i].prio > prio) begin
                                    pos = i;
                                    break;
                                end
                                if (waitq[i].prio == prio) begin
                                    pos = i + 1;
                                    break;
                                end
                            end
                        end
                        w.id   = tid;
                        w.prio = prio;
                        waitq.insert(pos, w);
                        if (waitq.size() > deepest) deepest = waitq.size();
                        r.st = STAT_QUEUED;
                    end
                end
            end
            ACT_RELEASE: begin
                if (sem_level != '1) sem_level++;
                if (waitq.size() > 0) begin
                    w       = waitq.pop_front();
                    r.woken = w.id;
                    r.st    = STAT_WOKE;
                end else begin
                    r.st = STAT_NO_WAITER;
                end
            end
            ACT_RESUME: begin
                if (tmo) begin
                    r.st = STAT_TIMEOUT;
                end else if (sem_level != 0) begin
                    sem_level--;
                    r.st = STAT_OK;
                end else begin
                    r.st = STAT_AGAIN;
                end
            end
            default: begin
            end
        endcase
        r.cnt = sem_level;
        return r;
    endfunction

    task automatic flag_error(string what, int got, int want);
        $display("ERROR at result %0d: %s got %0d, want %0d", results_seen, what, got, want);
        errors++;
    endtask

    task automatic send_item(
        logic [1:0]             act,
        logic [THREAD_BITS-1:0] tid,
        logic [PRIO_BITS-1:0]   prio,
        logic                   ww,
        logic                   sd,
        logic                   tmo,
        logic                   use_typed,
        result_t                typed
    );
        result_t r;
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({tmo, sd, ww, prio, tid});
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);
        r = semaphore_step(act, tid, prio, ww, sd, tmo);
        pending_results.push_back(use_typed ? typed : r);
        requests_sent++;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic wait_idle();
        drain_results();
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic apb_write(logic reg_sel, logic [COUNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({reg_sel, 2'b00});
        pwdata  <= PDATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_ORDER) prio_mode = value[0];
        else sem_level = value;
        @(posedge aclk);
    endtask

    task automatic random_item(int take_pct);
        int                   pick;
        logic [1:0]           act;
        logic [PRIO_BITS-1:0] prio;
        pick = $urandom_range(0, 99);
        if (pick < take_pct) act = ACT_TAKE;
        else if (pick < take_pct + 25) act = ACT_RELEASE;
        else if (pick < 96) act = ACT_RESUME;
        else act = ACT_SPARE;
        // half of the priorities from a few levels, so ties are common
        if ($urandom_range(0, 1) == 1) prio = PRIO_BITS'($urandom_range(0, 255));
        else prio = PRIO_BITS'($urandom_range(0, 3) * 85);
        send_item(act, THREAD_BITS'($urandom_range(0, 31)), prio,
                  $urandom_range(0, 9) != 0, $urandom_range(0, 9) == 0,
                  $urandom_range(0, 1) == 1, 1'b0, '0);
    endtask

    task automatic run_plan();
        result_t typed;
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                wait_idle();
                apb_write(plan[i].reg_sel, plan[i].cnt);
            end else begin
                typed.st    = plan[i].st;
                typed.woken = plan[i].woken;
                typed.cnt   = plan[i].cnt;
                for (int k = 0; k < plan[i].reps; k++) begin
                    send_item(plan[i].act, plan[i].tid + THREAD_BITS'(k),
                              plan[i].prio - PRIO_BITS'(k), plan[i].ww, plan[i].sd,
                              plan[i].tmo, plan[i].chk, typed);
                end
            end
        end
    endtask

    // response checker and activity counter
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (m_tvalid && m_tready) begin
                results_seen++;
                status_hits[m_tuser]++;
                if (pending_results.size() == 0) begin
                    flag_error("result with nothing pending, status", int'(m_tuser), 0);
                end else begin
                    popped = pending_results.pop_front();
                    if (m_tuser !== popped.st)
                        flag_error("status", int'(m_tuser), int'(popped.st));
                    if (m_tdata[THREAD_BITS-1:0] !== popped.woken)
                        flag_error("woken_thread", int'(m_tdata[THREAD_BITS-1:0]),
                                   int'(popped.woken));
                    if (m_tdata[THREAD_BITS +: COUNT_W] !== popped.cnt)
                        flag_error("count_now", int'(m_tdata[THREAD_BITS +: COUNT_W]),
                                   int'(popped.cnt));
                end
            end
        end
    end

    // result-side back-pressure
    initial begin
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold = 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_plan();
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            apb_write(REG_ORDER, COUNT_W'(phase_order[ph]));
            apb_write(REG_COUNT, COUNT_W'(phase_count[ph]));
            idle_on = (ph != PHASES - 1);
            if (ph == 1) long_hold = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 0 && n == PHASE_ITEMS / 2) drain_results();
                random_item(phase_take[ph]);
            end
        end
        wait_idle();
        $display("Ran %0d requests in FIFO and priority order, counts from 0 to 65535; %0d checked",
                 requests_sent, results_seen);
        $display("Wakes %0d, full-queue takes %0d, retakes of waiting threads %0d, deepest %0d",
                 status_hits[STAT_WOKE], status_hits[STAT_FULL], retakes, deepest);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/csem_pkg.sv
design/csem_ram.sv
design/counting_semaphore_priority_waitq_top.sv
bench/tb.sv
